// File: hw/rtl/nfci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nfci_pkg;

  // Field widths
  localparam int unsigned XW     = 32;  // Q16.16 abscissa / ordinate
  localparam int unsigned STEPW  = 31;  // step register
  localparam int unsigned CFG_IW = 3;   // register index width

  // Internal widths
  localparam int unsigned OFSW = 36;    // x - x_start and its shifted copies
  localparam int unsigned DIFW = 36;    // forward differences
  localparam int unsigned S1W  = 73;    // inner Horner sum
  localparam int unsigned S2W  = 110;   // middle Horner sum
  localparam int unsigned ACCW = 148;   // 6h^3 * exact value
  localparam int unsigned NW   = 152;   // offset rounding numerator
  localparam int unsigned RW   = 130;   // divider remainder
  localparam int unsigned QW   = 32;    // quotient bits

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_X_START = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_X_STEP  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_Y0      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_Y1      = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_Y2      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_Y3      = 3'd5;

  // Saturation codes
  localparam logic [XW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [XW-1:0] SAT_NEG = 32'h8000_0000;

endpackage

`default_nettype wire

// File: hw/rtl/nfci_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module nfci_mul #(
  parameter int unsigned WA = 36,
  parameter int unsigned WB = 36,
  parameter int unsigned CW = 32
) (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  wire  signed [WA-1:0]      a_i,
  input  wire  signed [WB-1:0]      b_i,
  output logic signed [WA+WB-1:0]   p_o
);

  localparam int unsigned NC = (WA + CW - 1) / CW;
  localparam int unsigned PW = CW + 1 + WB;
  localparam int unsigned OW = WA + WB;

  logic signed [NC*CW-1:0] a_ext;
  logic        [CW-1:0]    chunk   [NC];
  logic signed [PW-1:0]    part_d  [NC];
  logic signed [PW-1:0]    part_q  [NC];
  logic signed [OW-1:0]    sum_d;
  logic signed [OW-1:0]    p_q;

  assign a_ext = (NC*CW)'(a_i);

  // Form one partial product per chunk of a
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      chunk[k] = a_ext[k*CW +: CW];
      if (k == NC - 1) begin
        part_d[k] = $signed({chunk[k][CW-1], chunk[k]}) * b_i;
      end else begin
        part_d[k] = $signed({1'b0, chunk[k]}) * b_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q <= part_d;
    end
  end

  // Align and add the partial products
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NC; k++) begin
      sum_d = sum_d + (OW'(part_q[k]) <<< (k * CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: hw/rtl/newton_forward_cubic_interp_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one query per cycle; the 32-stage restoring divider, one quotient bit per
// stage, makes up most of the depth. A stalled output beat holds the whole pipeline.
// Reset: registers return to x_start 0, x_step 1.0, samples 0; the pipeline empties.
module newton_forward_cubic_interp_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [nfci_pkg::CFG_IW-1:0]       cfg_index_i,
  input  wire  [nfci_pkg::XW-1:0]           cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  signed [nfci_pkg::XW-1:0]    query_x_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [nfci_pkg::XW-1:0]    interp_value_o,
  output logic                              saturated_o
);

  localparam int unsigned XW   = nfci_pkg::XW;
  localparam int unsigned OFSW = nfci_pkg::OFSW;
  localparam int unsigned DIFW = nfci_pkg::DIFW;
  localparam int unsigned S1W  = nfci_pkg::S1W;
  localparam int unsigned S2W  = nfci_pkg::S2W;
  localparam int unsigned ACCW = nfci_pkg::ACCW;
  localparam int unsigned NW   = nfci_pkg::NW;
  localparam int unsigned RW   = nfci_pkg::RW;
  localparam int unsigned QW   = nfci_pkg::QW;
  localparam int unsigned NS   = 12 + QW;  // pipeline depth

  // Configuration registers
  logic signed [XW-1:0]              x_start_q, y0_q, y1_q, y2_q, y3_q;
  logic        [nfci_pkg::STEPW-1:0] x_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q <= '0;
      x_step_q  <= nfci_pkg::STEPW'(1) << FRAC_BITS;
      y0_q      <= '0;
      y1_q      <= '0;
      y2_q      <= '0;
      y3_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nfci_pkg::CFG_X_START: x_start_q <= cfg_data_i;
        nfci_pkg::CFG_X_STEP:  x_step_q  <= cfg_data_i[nfci_pkg::STEPW-1:0];
        nfci_pkg::CFG_Y0:      y0_q      <= cfg_data_i;
        nfci_pkg::CFG_Y1:      y1_q      <= cfg_data_i;
        nfci_pkg::CFG_Y2:      y2_q      <= cfg_data_i;
        nfci_pkg::CFG_Y3:      y3_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Constants derived from configuration run free; they settle before any query needs them
  logic        [nfci_pkg::STEPW-1:0] h_eff;
  logic signed [31:0]                h_q;
  logic signed [33:0]                h3x_q;
  logic signed [DIFW-1:0]            d1_q, d2_q, d3_q;
  logic signed [63:0]                h2_w;
  logic signed [65:0]                h2x6_q;
  logic signed [101:0]               q_w;
  logic signed [97:0]                den_w;
  logic signed [129:0]               t0_w;
  logic signed [69:0]                e_w;

  assign h_eff = (x_step_q == '0) ? nfci_pkg::STEPW'(1) : x_step_q;

  always_ff @(posedge clk_i) begin
    h_q    <= $signed({1'b0, h_eff});
    h3x_q  <= $signed(({3'b0, h_eff} << 1) + {3'b0, h_eff});
    d1_q   <= DIFW'(y1_q) - DIFW'(y0_q);
    d2_q   <= DIFW'(y2_q) - (DIFW'(y1_q) <<< 1) + DIFW'(y0_q);
    d3_q   <= DIFW'(y3_q) - (DIFW'(y2_q) <<< 1) - DIFW'(y2_q)
              + (DIFW'(y1_q) <<< 1) + DIFW'(y1_q) - DIFW'(y0_q);
    h2x6_q <= (66'(h2_w) <<< 2) + (66'(h2_w) <<< 1);
  end

  nfci_mul #(.WA(32), .WB(32), .CW(32)) u_mul_h2 (
    .clk_i, .en_i(1'b1), .a_i(h_q), .b_i(h_q), .p_o(h2_w)
  );
  nfci_mul #(.WA(34), .WB(DIFW), .CW(32)) u_mul_e (
    .clk_i, .en_i(1'b1), .a_i(h3x_q), .b_i(d2_q), .p_o(e_w)
  );
  nfci_mul #(.WA(66), .WB(DIFW), .CW(32)) u_mul_q (
    .clk_i, .en_i(1'b1), .a_i(h2x6_q), .b_i(d1_q), .p_o(q_w)
  );
  nfci_mul #(.WA(66), .WB(32), .CW(32)) u_mul_den (
    .clk_i, .en_i(1'b1), .a_i(h2x6_q), .b_i(h_q), .p_o(den_w)
  );
  nfci_mul #(.WA(98), .WB(XW), .CW(32)) u_mul_t0 (
    .clk_i, .en_i(1'b1), .a_i(den_w), .b_i(y0_q), .p_o(t0_w)
  );

  // Pipeline advance: stall everything while the output beat waits
  logic          en;
  logic [NS:1]   valid_q;

  assign en         = !valid_q[NS] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NS-1:1], in_valid_i};
    end
  end

  // Horner form: 6h^3 p = 6h^3 y0 + a(6h^2 d1 + b(3h d2 + c d3))
  logic signed [OFSW-1:0] a_q [1:7];
  logic signed [OFSW-1:0] b_q [1:4];
  logic signed [OFSW-1:0] c_q;
  logic signed [S1W-1:0]  s1_q;
  logic signed [S2W-1:0]  s2_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [NW-1:0]   np_q;
  logic signed [71:0]     m1_w;
  logic signed [108:0]    m2_w;
  logic signed [145:0]    m3_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[1] <= OFSW'(query_x_i) - OFSW'(x_start_q);
      b_q[1] <= OFSW'(query_x_i) - OFSW'(x_start_q) - OFSW'(h_eff);
      c_q    <= OFSW'(query_x_i) - OFSW'(x_start_q) - (OFSW'(h_eff) << 1);
      for (int k = 2; k <= 7; k++) begin
        a_q[k] <= a_q[k-1];
      end
      for (int k = 2; k <= 4; k++) begin
        b_q[k] <= b_q[k-1];
      end
      s1_q  <= S1W'(m1_w) + S1W'(e_w);
      s2_q  <= S2W'(m2_w) + S2W'(q_w);
      acc_q <= ACCW'(m3_w) + ACCW'(t0_w);
      np_q  <= (NW'(acc_q) <<< 1) + NW'(den_w) + (NW'(den_w) <<< 32);
    end
  end

  nfci_mul #(.WA(OFSW), .WB(DIFW), .CW(32)) u_mul_m1 (
    .clk_i, .en_i(en), .a_i(c_q), .b_i(d3_q), .p_o(m1_w)
  );
  nfci_mul #(.WA(S1W), .WB(OFSW), .CW(32)) u_mul_m2 (
    .clk_i, .en_i(en), .a_i(s1_q), .b_i(b_q[4]), .p_o(m2_w)
  );
  nfci_mul #(.WA(S2W), .WB(OFSW), .CW(32)) u_mul_m3 (
    .clk_i, .en_i(en), .a_i(s2_q), .b_i(a_q[7]), .p_o(m3_w)
  );

  // Range check and restoring division of the offset numerator by 12h^3
  logic [RW-1:0] div_w;
  logic [RW-1:0] rem_q  [0:QW-1];
  logic [QW-1:0] quo_q  [0:QW];
  logic          pos_q  [0:QW];
  logic          neg_q  [0:QW];
  logic [RW-1:0] trial  [1:QW];
  logic          ge     [1:QW];

  assign div_w = RW'(den_w) << 1;

  always_comb begin
    for (int j = 1; j <= QW; j++) begin
      trial[j] = div_w << (QW - j);
      ge[j]    = rem_q[j-1] >= trial[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0] <= np_q[NW-1];
      pos_q[0] <= !np_q[NW-1] && (np_q >= (NW'(den_w) <<< 33));
      rem_q[0] <= np_q[RW-1:0];
      quo_q[0] <= '0;
      for (int j = 1; j <= QW; j++) begin
        if (j < QW) begin
          rem_q[j] <= ge[j] ? rem_q[j-1] - trial[j] : rem_q[j-1];
        end
        quo_q[j] <= {quo_q[j-1][QW-2:0], ge[j]};
        pos_q[j] <= pos_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
  end

  // Drive the result beat; the quotient was offset by 2^31
  assign out_valid_o    = valid_q[NS];
  assign saturated_o    = pos_q[QW] || neg_q[QW];
  assign interp_value_o = pos_q[QW] ? nfci_pkg::SAT_POS :
                          neg_q[QW] ? nfci_pkg::SAT_NEG :
                          {~quo_q[QW][QW-1], quo_q[QW][QW-2:0]};

endmodule

`default_nettype wire
